// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define BGS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Checked on every edge, reset included.
`define BGS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// ----- sv/bgs_pkg.sv -----
// Shared constants, types and register codes for the gaze smoother.
// No dependencies.
package bgs_pkg;

    localparam int COORD_BITS   = 16;
    localparam int ALPHA_BITS   = 16;
    localparam int TICK_BITS    = 16;
    localparam int CFG_IDX_BITS = 2;
    localparam int IN_DATA_BITS  = 4 * COORD_BITS;
    localparam int OUT_DATA_BITS = 2 * COORD_BITS;

    typedef logic [COORD_BITS-1:0]   t_coord;
    typedef logic [ALPHA_BITS-1:0]   t_alpha;
    typedef logic [TICK_BITS-1:0]    t_ticks;
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_ALPHA   = t_cfg_idx'(0);
    localparam t_cfg_idx REG_TIMEOUT = t_cfg_idx'(1);

    localparam t_alpha ALPHA_RESET   = t_alpha'(9830);
    localparam t_ticks TIMEOUT_RESET = t_ticks'(500);
    localparam t_ticks TICK_MAX      = '1;

    // One staged input transaction, reduced to the point it contributes.
    typedef struct packed {
        logic   valid;
        logic   tick;
        logic   eye_ok;
        t_coord x;
        t_coord y;
    } t_item;

endpackage

// ----- sv/bgs_front.sv -----
// Input stage: picks the gaze point from the two eyes and registers it.
// Depends on bgs_pkg.
module bgs_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [bgs_pkg::IN_DATA_BITS-1:0] i_s_tdata,
    input  logic                          i_s_tuser,
    input  logic                          i_take,
    output bgs_pkg::t_item                o_item
);
    import bgs_pkg::*;

    t_coord lx, ly, rx, ry;
    logic   left_ok, right_ok;
    logic [COORD_BITS:0] sum_x, sum_y;
    t_item  n_item;
    t_item  r_item;
    logic   r_run;

    assign lx = i_s_tdata[0*COORD_BITS +: COORD_BITS];
    assign ly = i_s_tdata[1*COORD_BITS +: COORD_BITS];
    assign rx = i_s_tdata[2*COORD_BITS +: COORD_BITS];
    assign ry = i_s_tdata[3*COORD_BITS +: COORD_BITS];

    assign left_ok  = (lx != '0) && (ly != '0);
    assign right_ok = (rx != '0) && (ry != '0);
    assign sum_x = {1'b0, lx} + {1'b0, rx};
    assign sum_y = {1'b0, ly} + {1'b0, ry};

    assign o_s_tready = r_run && (!r_item.valid || i_take);

    always_comb begin
        n_item.valid  = 1'b1;
        n_item.tick   = i_s_tuser;
        n_item.eye_ok = left_ok || right_ok;
        priority if (left_ok && right_ok) begin
            n_item.x = sum_x[COORD_BITS:1];
            n_item.y = sum_y[COORD_BITS:1];
        end else if (left_ok) begin
            n_item.x = lx;
            n_item.y = ly;
        end else begin
            n_item.x = rx;
            n_item.y = ry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run        <= 1'b0;
            r_item.valid <= 1'b0;
        end else begin
            r_run <= 1'b1;
            if (o_s_tready) begin
                r_item.valid <= i_s_tvalid;
            end
        end
        if (o_s_tready && i_s_tvalid) begin
            r_item.tick   <= n_item.tick;
            r_item.eye_ok <= n_item.eye_ok;
            r_item.x      <= n_item.x;
            r_item.y      <= n_item.y;
        end
    end

    assign o_item = r_item;

endmodule

// ----- sv/bgs_ema.sv -----
// One axis of the moving average: s + floor(alpha * (x - s) / 2^16).
// Depends on bgs_pkg.
module bgs_ema (
    input  bgs_pkg::t_coord i_s,
    input  bgs_pkg::t_coord i_x,
    input  bgs_pkg::t_alpha i_alpha,
    output bgs_pkg::t_coord o_s
);
    import bgs_pkg::*;

    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int PROD_BITS = DIFF_BITS + ALPHA_BITS + 1;

    logic signed [DIFF_BITS-1:0]  diff;
    logic signed [ALPHA_BITS:0]   alpha_s;
    logic signed [PROD_BITS-1:0]  prod;

    assign diff    = $signed({1'b0, i_x}) - $signed({1'b0, i_s});
    assign alpha_s = $signed({1'b0, i_alpha});
    assign prod    = PROD_BITS'(diff) * PROD_BITS'(alpha_s);
    // arithmetic drop of the low bits floors; result wraps back into range
    assign o_s = i_s + prod[ALPHA_BITS +: COORD_BITS];

endmodule

// ----- sv/binocular_gaze_smoother.sv -----
// Top level of the binocular gaze smoother: config registers, track state,
// output register. Depends on bgs_pkg, bgs_front, bgs_ema.
//
//  channel   direction  handshake               payload
//  s         in         i_s_tvalid/o_s_tready   tdata lx,ly,rx,ry; tuser op
//  m         out        o_m_tvalid/i_m_tready   tdata pos_x,pos_y; tuser held
//  cfg       in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One transaction per cycle unless a result waits on a stalled output; a result passes
// the input register, then the result register with one multiply per axis.
// Synchronous active-low reset clears state and valids, resets config; ready rises
// the cycle after reset is released. Ticks and dropped samples retire even
// while the output is stalled; results wait in the output register.
module binocular_gaze_smoother (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [bgs_pkg::IN_DATA_BITS-1:0]  i_s_tdata,  // left_x, left_y, right_x, right_y
    input  logic                              i_s_tuser,  // op
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [bgs_pkg::OUT_DATA_BITS-1:0] o_m_tdata,  // pos_x, pos_y
    output logic                              o_m_tuser,  // held
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  bgs_pkg::t_cfg_idx                 i_cfg_index,
    input  logic [bgs_pkg::ALPHA_BITS-1:0]    i_cfg_data
);
    import bgs_pkg::*;

    t_item  item;
    t_alpha r_alpha;
    t_ticks r_timeout;
    t_ticks r_ticks;
    t_coord r_sx, r_sy;
    t_coord ema_x, ema_y;
    logic   r_cfg_ready;
    logic   r_out_valid, r_out_held;
    t_coord r_out_x, r_out_y;
    logic   lost, emits, out_free, take;

    bgs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_take     (take),
        .o_item     (item)
    );

    bgs_ema u_ema_x (.i_s(r_sx), .i_x(item.x), .i_alpha(r_alpha), .o_s(ema_x));
    bgs_ema u_ema_y (.i_s(r_sy), .i_x(item.y), .i_alpha(r_alpha), .o_s(ema_y));

    assign lost     = (r_ticks >= r_timeout);
    assign emits    = !item.tick && (item.eye_ok || !lost);
    assign out_free = !r_out_valid || i_m_tready;
    assign take     = item.valid && (out_free || !emits);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ready <= 1'b0;
            r_alpha     <= ALPHA_RESET;
            r_timeout   <= TIMEOUT_RESET;
            r_ticks     <= '0;
            r_sx        <= '0;
            r_sy        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cfg_ready <= 1'b1;
            if (i_cfg_valid && r_cfg_ready) begin
                if (i_cfg_index == REG_ALPHA) begin
                    r_alpha <= i_cfg_data;
                end else if (i_cfg_index == REG_TIMEOUT) begin
                    r_timeout <= i_cfg_data;
                end
            end

            if (take && emits) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            if (take) begin
                if (item.tick) begin
                    if (r_ticks != TICK_MAX) begin
                        r_ticks <= r_ticks + 1'b1;
                    end
                end else if (item.eye_ok) begin
                    r_ticks <= '0;
                    r_sx    <= lost ? item.x : ema_x;
                    r_sy    <= lost ? item.y : ema_y;
                end
            end
        end
        if (take && emits) begin
            r_out_held <= !item.eye_ok;
            if (item.eye_ok) begin
                r_out_x <= lost ? item.x : ema_x;
                r_out_y <= lost ? item.y : ema_y;
            end else begin
                r_out_x <= r_sx;
                r_out_y <= r_sy;
            end
        end
    end

    assign o_cfg_ready = r_cfg_ready;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {r_out_y, r_out_x};
    assign o_m_tuser   = r_out_held;

endmodule

// ----- sv/bgs_checker.sv -----
// Port-level checks for binocular_gaze_smoother, bound to the top level.
// Depends on bgs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bgs_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tvalid,
    input logic                              o_s_tready,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [bgs_pkg::OUT_DATA_BITS-1:0] o_m_tdata,
    input logic                              o_m_tuser
);
    import bgs_pkg::*;

    // A stalled result stays put.
    `BGS_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))

    // Input only backs up when the output is full and stalled.
    `BGS_ASSERT(a_no_bubble, i_clk, i_rst_n, $past(i_rst_n) && !o_s_tready |-> o_m_tvalid && !i_m_tready)

    // Reset empties the output register.
    `BGS_ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> !o_m_tvalid)

endmodule

bind binocular_gaze_smoother bgs_checker u_bgs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

// ----- dv/tb_binocular_gaze_smoother.sv -----
// Self-checking testbench for binocular_gaze_smoother: random and directed gaze
// samples and ticks, checked field by field against an in-bench EMA tracker.
// Depends on bgs_pkg and the binocular_gaze_smoother RTL.
module tb_binocular_gaze_smoother;
    timeunit 1ns;
    timeprecision 1ps;

    import bgs_pkg::*;

    localparam bit OP_SAMPLE = 1'b0;
    localparam bit OP_TICK   = 1'b1;

    // indexes past the register list; writes there must be dropped
    localparam t_cfg_idx REG_SPARE_LO = t_cfg_idx'(2);
    localparam t_cfg_idx REG_SPARE_HI = t_cfg_idx'(3);

    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   held;
    } t_gaze_pos;

    class smoothed_gaze_sb;
        t_alpha    alpha;
        t_ticks    lost_after;
        t_coord    sx;
        t_coord    sy;
        t_ticks    ticks;
        t_gaze_pos pending_positions[$];
        int        errors;

        function new();
            alpha      = ALPHA_RESET;
            lost_after = TIMEOUT_RESET;
            sx         = '0;
            sy         = '0;
            ticks      = '0;
            errors     = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [ALPHA_BITS-1:0] val);
            case (idx)
                REG_ALPHA:   alpha = val;
                REG_TIMEOUT: lost_after = val;
                default: ;
            endcase
        endfunction

        // s + floor(alpha * (x - s) / 2^16)
        function t_coord ema_step(t_coord s, t_coord x);
            longint diff;
            longint prod;
            diff = longint'(x) - longint'(s);
            prod = diff * longint'(alpha);
            return t_coord'(longint'(s) + (prod >>> 16));
        endfunction

        function void absorb_item(bit op, t_coord lx, t_coord ly, t_coord rx, t_coord ry);
            bit                  left_ok;
            bit                  right_ok;
            t_coord              px;
            t_coord              py;
            logic [COORD_BITS:0] sum_x;
            logic [COORD_BITS:0] sum_y;
            t_gaze_pos           pos;
            if (op == OP_TICK) begin
                if (ticks != TICK_MAX)
                    ticks++;
                return;
            end
            left_ok  = (lx != '0) && (ly != '0);
            right_ok = (rx != '0) && (ry != '0);
            if (!left_ok && !right_ok) begin
                // lost track: repeat the held point only while inside the timeout
                if (ticks < lost_after) begin
                    pos.x    = sx;
                    pos.y    = sy;
                    pos.held = 1'b1;
                    pending_positions.push_back(pos);
                end
                return;
            end
            if (left_ok && right_ok) begin
                sum_x = lx + rx;
                sum_y = ly + ry;
                px    = sum_x[COORD_BITS:1];
                py    = sum_y[COORD_BITS:1];
            end else if (left_ok) begin
                px = lx;
                py = ly;
            end else begin
                px = rx;
                py = ry;
            end
            if (ticks >= lost_after) begin
                sx = px;
                sy = py;
            end else begin
                sx = ema_step(sx, px);
                sy = ema_step(sy, py);
            end
            ticks    = '0;
            pos.x    = sx;
            pos.y    = sy;
            pos.held = 1'b0;
            pending_positions.push_back(pos);
        endfunction

        function void report(string what, int exp_v, int act_v);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %h, actual %h", $time, what, exp_v, act_v);
        endfunction

        function void check_position(t_coord x, t_coord y, logic held);
            t_gaze_pos want;
            if (pending_positions.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result: expected none, actual x=%h y=%h held=%b",
                             $time, x, y, held);
                return;
            end
            want = pending_positions.pop_front();
            if (x !== want.x)
                report("pos_x", want.x, x);
            if (y !== want.y)
                report("pos_y", want.y, y);
            if (held !== want.held)
                report("held", want.held, held);
        endfunction

        function int pending();
            return pending_positions.size();
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_s_tvalid;
    logic                     o_s_tready;
    logic [IN_DATA_BITS-1:0]  i_s_tdata;   // left_x, left_y, right_x, right_y
    logic                     i_s_tuser;   // op
    logic                     o_m_tvalid;
    logic                     i_m_tready;
    logic [OUT_DATA_BITS-1:0] o_m_tdata;   // pos_x, pos_y
    logic                     o_m_tuser;   // held
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    t_cfg_idx                 i_cfg_index;
    logic [ALPHA_BITS-1:0]    i_cfg_data;

    smoothed_gaze_sb sb = new();

    bit src_burst;
    bit snk_burst;
    int snk_hold_cycles;

    binocular_gaze_smoother u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_position(o_m_tdata[COORD_BITS-1:0],
                              o_m_tdata[2*COORD_BITS-1:COORD_BITS], o_m_tuser);
    end

    // result side: random stalls, plus a long hold-off on request
    initial begin : result_sink
        int stall;
        i_m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (snk_hold_cycles > 0) begin
                i_m_tready <= 1'b0;
                repeat (snk_hold_cycles) @(posedge i_clk);
                snk_hold_cycles = 0;
            end
            stall = snk_burst ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid && snk_hold_cycles == 0);
        end
    end

    // called at a rising edge; returns at the edge of the transaction
    task automatic push_item(bit op, t_coord lx, t_coord ly, t_coord rx, t_coord ry);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {ry, rx, ly, lx};
        do @(posedge i_clk); while (!o_s_tready);
        sb.absorb_item(op, lx, ly, rx, ry);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [ALPHA_BITS-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
    endtask

    task automatic program_track(t_alpha a, t_ticks lost);
        write_reg(REG_ALPHA, a);
        write_reg(REG_TIMEOUT, lost);
        write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                  ALPHA_BITS'($urandom_range(0, 65535)));
        i_cfg_valid <= 1'b0;
    endtask

    // block goes quiet: nothing pending, pipeline flushed
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic t_coord live_coord();
        case ($urandom_range(0, 9))
            0:       return t_coord'(1);
            1:       return '1;
            default: return t_coord'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic t_coord any_coord();
        return ($urandom_range(0, 7) == 0) ? '0 : live_coord();
    endfunction

    // eye with at least one coordinate missing
    task automatic broken_eye(output t_coord cx, output t_coord cy);
        cx = any_coord();
        cy = any_coord();
        case ($urandom_range(0, 2))
            0: cx = '0;
            1: cy = '0;
            default: begin
                cx = '0;
                cy = '0;
            end
        endcase
    endtask

    task automatic random_item();
        int     kind;
        int     burst_len;
        t_coord lx, ly, rx, ry;
        kind = $urandom_range(0, 99);
        if (kind < 25) begin
            if ($urandom_range(0, 19) == 0) begin
                burst_len = (sb.lost_after > 0 && sb.lost_after < 64) ?
                            $urandom_range(1, sb.lost_after + 2) : $urandom_range(1, 20);
                repeat (burst_len)
                    push_item(OP_TICK, any_coord(), any_coord(), any_coord(), any_coord());
            end else begin
                push_item(OP_TICK, any_coord(), any_coord(), any_coord(), any_coord());
            end
            return;
        end
        lx = live_coord();
        ly = live_coord();
        rx = live_coord();
        ry = live_coord();
        if (kind >= 88) begin
            broken_eye(lx, ly);
            broken_eye(rx, ry);
        end else if (kind >= 75) begin
            if ($urandom_range(0, 1))
                broken_eye(lx, ly);
            else
                broken_eye(rx, ry);
        end
        push_item(OP_SAMPLE, lx, ly, rx, ry);
    endtask

    initial begin : stimulus
        t_alpha phase_alpha[6];
        t_ticks phase_lost[6];
        i_rst_n         = 1'b0;
        i_s_tvalid      = 1'b0;
        i_s_tdata       = '0;
        i_s_tuser       = OP_SAMPLE;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = REG_ALPHA;
        i_cfg_data      = '0;
        src_burst       = 1'b0;
        snk_burst       = 1'b0;
        snk_hold_cycles = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: held point before any sample, blends, eye selection
        push_item(OP_SAMPLE, '0, '0, '0, '0);
        push_item(OP_TICK, '0, '0, '0, '0);
        push_item(OP_SAMPLE, '1, '1, '1, '1);
        push_item(OP_SAMPLE, 16'h0001, 16'h8001, 16'h0002, 16'h8000);   // odd sums
        push_item(OP_SAMPLE, 16'h1234, 16'hABCD, 16'h0000, 16'hFFFF);   // left only
        push_item(OP_SAMPLE, 16'hFFFF, 16'h0000, 16'h00FF, 16'hFF00);   // right only
        push_item(OP_SAMPLE, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);   // neither
        push_item(OP_TICK, '1, '1, '1, '1);
        settle();

        // full weight, shortest nonzero timeout
        program_track('1, t_ticks'(1));
        push_item(OP_TICK, '0, '0, '0, '0);
        push_item(OP_SAMPLE, '0, '0, '0, '0);                           // lost: no result
        push_item(OP_SAMPLE, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);   // loads
        push_item(OP_SAMPLE, 16'h0001, 16'h0001, 16'h0001, 16'h0001);
        push_item(OP_SAMPLE, 16'h0000, 16'h0001, 16'h0001, 16'h0000);   // held
        settle();

        // zero timeout: every sample loads, invalid samples never answer
        program_track('0, '0);
        push_item(OP_SAMPLE, 16'hF00D, 16'h0F0F, 16'hF00D, 16'h0F0F);
        push_item(OP_SAMPLE, 16'h0001, 16'hFFFF, 16'h0000, 16'h0000);
        push_item(OP_SAMPLE, '0, '0, '0, '0);
        push_item(OP_TICK, '0, '0, '0, '0);
        settle();

        // smallest weight: downward step still moves by one
        program_track(t_alpha'(1), t_ticks'(2));
        push_item(OP_SAMPLE, 16'h0001, 16'h0001, 16'h0001, 16'h0001);
        push_item(OP_SAMPLE, '1, '1, '1, '1);
        settle();

        // longest timeout: a run of ticks stays well inside it
        program_track(t_alpha'($urandom_range(0, 65535)), TICK_MAX);
        push_item(OP_SAMPLE, 16'h4000, 16'hC000, 16'h4000, 16'hC000);
        src_burst = 1'b1;
        repeat (20) push_item(OP_TICK, '0, '0, '0, '0);
        src_burst = 1'b0;
        push_item(OP_SAMPLE, '0, '0, '0, '0);
        push_item(OP_SAMPLE, 16'h0123, 16'h4567, 16'h0123, 16'h4567);
        push_item(OP_SAMPLE, '0, '0, '0, '0);
        settle();

        phase_alpha = '{16'hFFFF, 16'h0000, 16'h0001, ALPHA_RESET, 16'h8000,
                        t_alpha'($urandom_range(0, 65535))};
        phase_lost  = '{16'd1, 16'd0, 16'hFFFF, 16'd4, 16'd12,
                        t_ticks'($urandom_range(1, 30))};
        for (int p = 0; p < 6; p++) begin
            program_track(phase_alpha[p], phase_lost[p]);
            src_burst = (p % 3 == 1);
            snk_burst = (p % 3 == 2);
            for (int n = 0; n < 195; n++) begin
                random_item();
                if (p == 0 && n == 100) begin
                    // receiver holds off while samples keep coming
                    snk_hold_cycles = 150;
                    src_burst = 1'b1;
                    repeat (40)
                        push_item(OP_SAMPLE, live_coord(), live_coord(),
                                  live_coord(), live_coord());
                    src_burst = 1'b0;
                end
            end
            settle();
        end

        src_burst = 1'b0;
        snk_burst = 1'b0;
        settle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
